// File: rtl/ptw_pkg.sv
`default_nettype none

package ptw_pkg;

    // Default width of the physical address field held in a table entry
    localparam int PHYS_BITS_DEF = 36;

    // Classified-word queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input word kinds
    localparam logic KIND_REQ   = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Result word kinds
    localparam logic OUT_READ = 1'b0;
    localparam logic OUT_DONE = 1'b1;

    // Walk levels (level whose entry is awaited)
    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_GB   = 2'd1;
    localparam logic [1:0] LVL_MB   = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    // Entry flag positions
    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    // Classified word handed from front to back
    typedef struct packed {
        logic        is_reply;
        logic [51:0] addr;       // request: first read address; reply: masked field
        logic [47:0] va;         // request only
        logic        present;
        logic        page_size;
        logic        field_zero;
        logic [21:0] gb_base;    // entry bits 51:30
    } ptw_item_t;

    // 9-bit table index for a given level
    function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] lvl);
        logic [8:0] idx;
        begin
            case (lvl)
                LVL_GB:   idx = va[38:30];
                LVL_MB:   idx = va[29:21];
                LVL_LEAF: idx = va[20:12];
                default:  idx = va[47:39];
            endcase
            return idx;
        end
    endfunction

    // Byte offset of an 8-byte entry within a table
    function automatic logic [51:0] entry_offset(input logic [8:0] idx);
        return {40'd0, idx, 3'b000};
    endfunction

endpackage

`default_nettype wire

// File: rtl/ptw_if.sv
`default_nettype none

// Incoming words: translate requests and memory read replies
interface ptw_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [51:0] table_base;
    logic [47:0] virt_addr;
    logic [63:0] read_data;

    modport source (output valid, req_type, table_base, virt_addr, read_data, input ready);
    modport sink   (input valid, req_type, table_base, virt_addr, read_data, output ready);
endinterface

// Outgoing words: memory read requests and finished translations
interface ptw_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [51:0] mem_addr;
    logic [51:0] phys_addr;
    logic        fault;

    modport source (output valid, out_kind, mem_addr, phys_addr, fault, input ready);
    modport sink   (input valid, out_kind, mem_addr, phys_addr, fault, output ready);
endinterface

`default_nettype wire

// File: rtl/ptw_front.sv
`default_nettype none

module ptw_front
    import ptw_pkg::*;
#(
    parameter int PHYS_BITS = PHYS_BITS_DEF
)
(
    ptw_in_if.sink    walk_in,
    output logic      push_valid,
    input  logic      push_ready,
    output ptw_item_t push_item
);

    // Address field of an entry: bits 12 .. PHYS_BITS-1
    localparam logic [51:0] FIELD_MASK =
        ((52'd1 << PHYS_BITS) - 52'd1) & ~52'hFFF;

    logic [51:0] req_base;
    logic [51:0] req_addr;
    logic [51:0] field;

    // Request: top-level entry address, base aligned to 16 bytes
    assign req_base = {walk_in.table_base[51:4], 4'b0000};
    assign req_addr = req_base + entry_offset(level_index(walk_in.virt_addr, LVL_TOP));

    // Reply: pull apart the entry
    assign field = walk_in.read_data[51:0] & FIELD_MASK;

    always_comb
    begin
        push_item.is_reply   = (walk_in.req_type == KIND_REPLY);
        push_item.addr       = (walk_in.req_type == KIND_REPLY) ? field : req_addr;
        push_item.va         = walk_in.virt_addr;
        push_item.present    = walk_in.read_data[PRESENT_BIT];
        push_item.page_size  = walk_in.read_data[LARGE_BIT];
        push_item.field_zero = (field == 52'd0);
        push_item.gb_base    = walk_in.read_data[51:30];
    end

    assign push_valid    = walk_in.valid;
    assign walk_in.ready = push_ready;

endmodule

`default_nettype wire

// File: rtl/ptw_queue.sv
`default_nettype none

module ptw_queue
    import ptw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  ptw_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output ptw_item_t pop_item
);

    ptw_item_t         store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ptw_back.sv
`default_nettype none

module ptw_back
    import ptw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  ptw_item_t  pop_item,
    ptw_out_if.source  walk_out
);

    // Walk state
    logic        busy_reg, busy_next;
    logic [1:0]  level_reg, level_next;
    logic [47:0] va_reg, va_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [51:0] mem_addr_reg, mem_addr_next;
    logic [51:0] phys_addr_reg, phys_addr_next;
    logic        fault_reg, fault_next;

    logic        has_result;
    logic        out_free;
    logic        do_pop;
    logic [1:0]  level_inc;
    logic [51:0] next_read;

    // A stray reply while idle makes no word and may always drain
    assign has_result = !pop_item.is_reply || busy_reg;
    assign out_free   = !out_valid_reg || walk_out.ready;
    assign pop_ready  = out_free || !has_result;
    assign do_pop     = pop_valid && pop_ready;

    assign level_inc = level_reg + 2'd1;
    assign next_read = pop_item.addr + entry_offset(level_index(va_reg, level_inc));

    always_comb
    begin
        busy_next      = busy_reg;
        level_next     = level_reg;
        va_next        = va_reg;
        out_valid_next = out_valid_reg && !walk_out.ready;
        out_kind_next  = out_kind_reg;
        mem_addr_next  = mem_addr_reg;
        phys_addr_next = phys_addr_reg;
        fault_next     = fault_reg;

        if (do_pop && has_result)
        begin
            out_valid_next = 1'b1;
            // default: walk ends
            out_kind_next  = OUT_DONE;
            mem_addr_next  = '0;
            phys_addr_next = '0;
            fault_next     = 1'b0;
            busy_next      = 1'b0;
            level_next     = LVL_TOP;

            if (!pop_item.is_reply)
            begin
                // fresh walk, abandons any walk in progress
                va_next       = pop_item.va;
                busy_next     = 1'b1;
                out_kind_next = OUT_READ;
                mem_addr_next = pop_item.addr;
            end
            else if (level_reg == LVL_LEAF)
            begin
                fault_next     = pop_item.field_zero;
                phys_addr_next = pop_item.field_zero ? 52'd0
                                                     : (pop_item.addr | {40'd0, va_reg[11:0]});
            end
            else if (!pop_item.present)
            begin
                fault_next = 1'b1;
            end
            else if (level_reg == LVL_GB && pop_item.page_size)
            begin
                phys_addr_next = {pop_item.gb_base, va_reg[29:0]};
            end
            else if (level_reg == LVL_MB && pop_item.page_size)
            begin
                phys_addr_next = {pop_item.addr[51:21], va_reg[20:0]};
            end
            else
            begin
                // descend one level
                busy_next     = 1'b1;
                level_next    = level_inc;
                out_kind_next = OUT_READ;
                mem_addr_next = next_read;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            level_reg     <= LVL_TOP;
            va_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            level_reg     <= level_next;
            va_reg        <= va_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output word, no reset
    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        mem_addr_reg  <= mem_addr_next;
        phys_addr_reg <= phys_addr_next;
        fault_reg     <= fault_next;
    end

    assign walk_out.valid     = out_valid_reg;
    assign walk_out.out_kind  = out_kind_reg;
    assign walk_out.mem_addr  = mem_addr_reg;
    assign walk_out.phys_addr = phys_addr_reg;
    assign walk_out.fault     = fault_reg;

endmodule

`default_nettype wire

// File: rtl/four_level_page_table_walker.sv
`default_nettype none
// Path: an accepted word goes first into the classified-word queue, then its
//   result word, if any, into the output register.
// Throughput: one word per cycle unless walk_out stalls the output register.
// Reset: rst_n clears the walk state, the queue pointers and the output valid;
//   the walker starts idle and a reply that arrives while idle is dropped.
module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int PHYS_BITS = PHYS_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptw_in_if.sink     walk_in,
    ptw_out_if.source  walk_out
);

    logic      push_valid, push_ready;
    ptw_item_t push_item;
    logic      pop_valid, pop_ready;
    ptw_item_t pop_item;

    // Classify incoming words
    ptw_front #(
        .PHYS_BITS (PHYS_BITS)
    ) u_front (
        .walk_in    (walk_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue
    ptw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Walk sequencing and result words
    ptw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .walk_out  (walk_out)
    );

endmodule

`default_nettype wire
